// ===== hdl/ebalu_pkg.sv =====
// ---------------------------------------------------------------------------
// ebalu_pkg
// Shared types and constants for the eight-bit CPU ALU with flags.
// ---------------------------------------------------------------------------
package ebalu_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned FLAG_W = 4;

    // Flag bit positions within the packed flag nibble
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD8  = 5'd0,
        OP_SUB8  = 5'd1,
        OP_AND   = 5'd2,
        OP_OR    = 5'd3,
        OP_XOR   = 5'd4,
        OP_INC8  = 5'd5,
        OP_DEC8  = 5'd6,
        OP_SWAP  = 5'd7,
        OP_RL    = 5'd8,
        OP_RLC   = 5'd9,
        OP_RR    = 5'd10,
        OP_RRC   = 5'd11,
        OP_SLA   = 5'd12,
        OP_SRA   = 5'd13,
        OP_SRL   = 5'd14,
        OP_BIT   = 5'd15,
        OP_SET   = 5'd16,
        OP_RES   = 5'd17,
        OP_ADD16 = 5'd18,
        OP_INC16 = 5'd19,
        OP_DEC16 = 5'd20
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [IDX_W-1:0]  bit_index;
        logic [FLAG_W-1:0] flags_in;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic [FLAG_W-1:0] flags_out;
        logic              result_valid;
    } t_res;

endpackage

// ===== hdl/eight_bit_cpu_alu_with_flags.sv =====
// An item taken into the input register passes the datapath into the result
// register; its result is then on the outputs, with o_done high for a single cycle.
// Throughput: one item per cycle; busy stays low, and the input register
// feeds the single-pass datapath into the result register.
// Reset: synchronous, active low; clears the item-valid and done strobes.
// Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags
// Registered eight-bit CPU ALU with Z/N/H/C flag generation.
// ---------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ebalu_pkg::OP_W-1:0]        i_op,
    input  logic [ebalu_pkg::WORD_W-1:0]      i_operand_a,
    input  logic [ebalu_pkg::WORD_W-1:0]      i_operand_b,
    input  logic [ebalu_pkg::IDX_W-1:0]       i_bit_index,
    input  logic [ebalu_pkg::FLAG_W-1:0]      i_flags_in,
    output logic                              o_done,
    output logic [ebalu_pkg::WORD_W-1:0]      o_result,
    output logic [ebalu_pkg::FLAG_W-1:0]      o_flags_out,
    output logic                              o_result_valid
);

    ebalu_pkg::t_item r_in;
    logic             r_in_vld;
    ebalu_pkg::t_res  n_res;
    ebalu_pkg::t_res  r_res;
    logic             r_done;
    logic             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_in_vld <= accept;
            r_done   <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.op        <= i_op;
            r_in.operand_a <= i_operand_a;
            r_in.operand_b <= i_operand_b;
            r_in.bit_index <= i_bit_index;
            r_in.flags_in  <= i_flags_in;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    ebalu_exec u_exec (
        .i_item (r_in),
        .o_res  (n_res)
    );

    assign o_done         = r_done;
    assign o_result       = r_res.result;
    assign o_flags_out    = r_res.flags_out;
    assign o_result_valid = r_res.result_valid;

    // every strobe traces back to an item held in the input register
    a_done_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_in_vld))
        else $error("result strobe without a preceding item");

    // an item in the input register always yields a strobe next cycle
    a_item_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_done)
        else $error("item lost between input and result register");

    // a result that is not written back carries a zero value
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result_valid) |-> (o_result == '0))
        else $error("non-written result is not zero");

    // bit test never writes back
    a_bit_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in.op == ebalu_pkg::OP_BIT) |=> (o_done && !o_result_valid))
        else $error("bit test marked as written");

endmodule

// ===== hdl/ebalu_exec.sv =====
// ---------------------------------------------------------------------------
// ebalu_exec
// Single-pass ALU datapath: result, flags and write-back mark for one item.
// ---------------------------------------------------------------------------
module ebalu_exec (
    input  ebalu_pkg::t_item i_item,
    output ebalu_pkg::t_res  o_res
);

    logic [ebalu_pkg::BYTE_W-1:0] a;
    logic [ebalu_pkg::BYTE_W-1:0] b;
    logic                         cin;
    logic [ebalu_pkg::BYTE_W:0]   sum9;
    logic [4:0]                   hsum5;
    logic [ebalu_pkg::BYTE_W:0]   diff9;
    logic [ebalu_pkg::WORD_W:0]   sum17;
    logic [12:0]                  hsum13;
    logic [ebalu_pkg::BYTE_W-1:0] mask;
    logic [ebalu_pkg::BYTE_W-1:0] r8;
    logic [ebalu_pkg::WORD_W-1:0] r16;
    logic                         wide;
    logic [ebalu_pkg::FLAG_W-1:0] f;
    logic                         vld;

    assign a      = i_item.operand_a[ebalu_pkg::BYTE_W-1:0];
    assign b      = i_item.operand_b[ebalu_pkg::BYTE_W-1:0];
    assign cin    = i_item.flags_in[ebalu_pkg::FLAG_C];
    assign sum9   = {1'b0, a} + {1'b0, b};
    assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
    assign diff9  = {1'b0, a} - {1'b0, b};
    assign sum17  = {1'b0, i_item.operand_a} + {1'b0, i_item.operand_b};
    assign hsum13 = {1'b0, i_item.operand_a[11:0]} + {1'b0, i_item.operand_b[11:0]};
    assign mask   = ebalu_pkg::BYTE_W'(1) << i_item.bit_index;

    always_comb begin
        r8   = '0;
        r16  = '0;
        wide = 1'b0;
        f    = i_item.flags_in;
        vld  = 1'b1;
        case (i_item.op)
            ebalu_pkg::OP_ADD8: begin
                r8 = sum9[7:0];
                f  = {r8 == 8'h00, 1'b0, hsum5[4], sum9[8]};
            end
            ebalu_pkg::OP_SUB8: begin
                r8 = diff9[7:0];
                f  = {r8 == 8'h00, 1'b1, a[3:0] < b[3:0], diff9[8]};
            end
            ebalu_pkg::OP_AND: begin
                r8 = a & b;
                f  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            ebalu_pkg::OP_OR: begin
                r8 = a | b;
                f  = {r8 == 8'h00, 3'b000};
            end
            ebalu_pkg::OP_XOR: begin
                r8 = a ^ b;
                f  = {r8 == 8'h00, 3'b000};
            end
            ebalu_pkg::OP_INC8: begin
                r8 = a + 8'd1;
                f  = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
            end
            ebalu_pkg::OP_DEC8: begin
                // half-borrow judged on the original operand
                r8 = a - 8'd1;
                f  = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
            end
            ebalu_pkg::OP_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                f  = {r8 == 8'h00, 3'b000};
            end
            ebalu_pkg::OP_RL: begin
                r8 = {a[6:0], cin};
                f  = {r8 == 8'h00, 2'b00, a[7]};
            end
            ebalu_pkg::OP_RLC: begin
                r8 = {a[6:0], a[7]};
                f  = {r8 == 8'h00, 2'b00, a[7]};
            end
            ebalu_pkg::OP_RR: begin
                r8 = {cin, a[7:1]};
                f  = {r8 == 8'h00, 2'b00, a[0]};
            end
            ebalu_pkg::OP_RRC: begin
                r8 = {a[0], a[7:1]};
                f  = {r8 == 8'h00, 2'b00, a[0]};
            end
            ebalu_pkg::OP_SLA: begin
                r8 = {a[6:0], 1'b0};
                f  = {r8 == 8'h00, 2'b00, a[7]};
            end
            ebalu_pkg::OP_SRA: begin
                r8 = {a[7], a[7:1]};
                f  = {r8 == 8'h00, 2'b00, a[0]};
            end
            ebalu_pkg::OP_SRL: begin
                r8 = {1'b0, a[7:1]};
                f  = {r8 == 8'h00, 2'b00, a[0]};
            end
            ebalu_pkg::OP_BIT: begin
                vld = 1'b0;
                f   = {(a & mask) == 8'h00, 1'b0, 1'b1, cin};
            end
            ebalu_pkg::OP_SET: begin
                r8 = a | mask;
            end
            ebalu_pkg::OP_RES: begin
                r8 = a & ~mask;
            end
            ebalu_pkg::OP_ADD16: begin
                wide = 1'b1;
                r16  = sum17[15:0];
                f    = {i_item.flags_in[ebalu_pkg::FLAG_Z], 1'b0, hsum13[12], sum17[16]};
            end
            ebalu_pkg::OP_INC16: begin
                wide = 1'b1;
                r16  = i_item.operand_a + 16'd1;
            end
            ebalu_pkg::OP_DEC16: begin
                wide = 1'b1;
                r16  = i_item.operand_a - 16'd1;
            end
            default: begin
                // unused codes: no operation, nothing written
                vld = 1'b0;
            end
        endcase
    end

    assign o_res.result       = wide ? r16 : {8'h00, r8};
    assign o_res.flags_out    = f;
    assign o_res.result_valid = vld;

endmodule
